/* src/bsm_pkg.sv */
// Shared types and constants for the 3x3 box smoothing block.
// No dependencies; imported by the datapath, controller, divider and top level.
package bsm_pkg;

  localparam int PIX_W    = 8;   // pixel and result intensity
  localparam int POS_W    = 4;   // row and column fields of a result
  localparam int SIZE_W   = 5;   // image_size register
  localparam int MIN_SIDE = 2;
  localparam int CS_W     = 10;  // one column of up to three pixels
  localparam int SUM_W    = 12;  // up to nine pixels
  localparam int CNT_W    = 4;   // pixel count: 4, 6 or 9
  localparam int DIVD_W   = SUM_W + 1;   // 2*sum + count
  localparam int DIVS_W   = CNT_W + 1;   // 2*count
  localparam int REC_W    = 18;  // scaled reciprocal of 2*count
  localparam int REC_SHIFT = 20; // reciprocal scale, exact for any 13-bit dividend
  localparam int NUM_BUFS = 3;   // rotating line buffers
  localparam int ROT_W    = 2;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;         // take the accepted pixel, write it to the current row
    logic advance;      // step the input position, rotate rows at row end
    logic shift;        // push a new column sum into the window
    logic edge_clr;     // next mean is centered one column back
    logic edge_set;     // next mean is centered on the newest column
    logic div_start;    // launch the divider on the selected window
    logic out_load;     // capture quotient and position into the output register
    logic scan_next;    // step the flush scan column
    logic flush_start;  // begin scanning the final row
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic row_zero;
    logic scol_zero;
    logic scol_last;
    logic last_pixel;
    logic flush;
    logic edge_mode;
    logic div_busy;
  } status_t;

  // Pixel count of a neighborhood from its row and column extents.
  function automatic logic [CNT_W-1:0] box_count(input logic three_rows,
                                                 input logic three_cols);
    logic [CNT_W-1:0] cnt;
    case ({three_rows, three_cols})
      2'b00:   cnt = CNT_W'(4);
      2'b01:   cnt = CNT_W'(6);
      2'b10:   cnt = CNT_W'(6);
      2'b11:   cnt = CNT_W'(9);
      default: cnt = CNT_W'(9);
    endcase
    return cnt;
  endfunction

endpackage

/* src/bsm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/bsm_div.sv */
// Mean divider: multiplies by a scaled reciprocal of 2*count; operands and quotient are registered.
// Depends on bsm_pkg.
module bsm_div
  import bsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              busy,
  output logic [DIVD_W-1:0] quotient
);

  localparam int PROD_W = DIVD_W + REC_W;
  localparam int REC_8  = ((1 << REC_SHIFT) + 7) / 8;
  localparam int REC_12 = ((1 << REC_SHIFT) + 11) / 12;
  localparam int REC_18 = ((1 << REC_SHIFT) + 17) / 18;

  logic [DIVD_W-1:0] dvd;
  logic [REC_W-1:0]  recip;
  logic [PROD_W-1:0] product;

  assign product = PROD_W'(dvd) * PROD_W'(recip);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= start;
    end
  end

  // Latch the operands, then take the scaled product in the following cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      case (divisor)
        DIVS_W'(8):  recip <= REC_W'(REC_8);
        DIVS_W'(12): recip <= REC_W'(REC_12);
        default:     recip <= REC_W'(REC_18);
      endcase
    end
    if (busy) begin
      quotient <= DIVD_W'(product >> REC_SHIFT);
    end
  end

endmodule

/* src/bsm_dp.sv */
// Datapath: line buffers, position counters, column-sum window, divider, output register.
// Depends on bsm_pkg, bsm_ram and bsm_div.
module bsm_dp
  import bsm_pkg::*;
#(
  parameter int MAX_SIDE = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [SIZE_W-1:0] image_size,
  input  logic [PIX_W-1:0]  pixel,
  input  cmd_t              cmd,
  output status_t           status,
  output logic [PIX_W-1:0]  smoothed,
  output logic [POS_W-1:0]  out_row,
  output logic [POS_W-1:0]  out_col,
  output logic              last_of_run,
  output logic              frame_done
);

  localparam int CW         = $clog2(MAX_SIDE);
  localparam int RESET_SIDE = (MAX_SIDE < 16) ? MAX_SIDE : 16;

  logic [CW-1:0]    side_m1;
  logic [CW-1:0]    row;
  logic [CW-1:0]    col;
  logic [CW-1:0]    scol;
  logic [ROT_W-1:0] rot;
  logic             flush;
  logic             edge_sel;
  logic [CS_W-1:0]  w0, w1, w2;

  logic [31:0]       nm1_w;
  logic [PIX_W-1:0]  ram_q [NUM_BUFS];
  logic [PIX_W-1:0]  older, recent, current;
  logic              use_older;
  logic              three_cols;
  logic [CS_W-1:0]   colsum;
  logic [SUM_W-1:0]  box_sum;
  logic [CNT_W-1:0]  cnt;
  logic [DIVD_W-1:0] dividend;
  logic [DIVD_W-1:0] quotient;
  logic              div_busy;
  logic              last_pixel;
  logic              scol_last;

  // Clamp the configured side and keep it as side minus one.
  always_comb begin
    if (image_size < SIZE_W'(MIN_SIDE)) begin
      nm1_w = 32'd1;
    end else if (32'(image_size) > MAX_SIDE) begin
      nm1_w = 32'(MAX_SIDE - 1);
    end else begin
      nm1_w = 32'(image_size) - 32'd1;
    end
  end

  for (genvar k = 0; k < NUM_BUFS; k++) begin : g_buf
    bsm_ram #(
      .WIDTH(PIX_W),
      .DEPTH(MAX_SIDE)
    ) u_ram (
      .clk  (clk),
      .we   (cmd.load && (rot == ROT_W'(k))),
      .waddr(col),
      .wdata(pixel),
      .raddr(scol),
      .rdata(ram_q[k])
    );
  end

  // Role of each buffer follows the rotation index.
  always_comb begin
    case (rot)
      ROT_W'(0): begin
        current = ram_q[0]; older = ram_q[1]; recent = ram_q[2];
      end
      ROT_W'(1): begin
        current = ram_q[1]; older = ram_q[2]; recent = ram_q[0];
      end
      default: begin
        current = ram_q[2]; older = ram_q[0]; recent = ram_q[1];
      end
    endcase
  end

  assign use_older  = !flush && (row > CW'(1));
  assign colsum     = CS_W'(use_older ? older : '0) + CS_W'(recent) + CS_W'(current);
  assign three_cols = !edge_sel && (scol > CW'(1));
  assign box_sum    = SUM_W'(w0) + SUM_W'(w1) + SUM_W'(three_cols ? w2 : '0);
  assign cnt        = box_count(use_older, three_cols);
  assign dividend   = DIVD_W'({box_sum, 1'b0}) + DIVD_W'(cnt);
  assign last_pixel = (row == side_m1) && (col == side_m1);
  assign scol_last  = (scol == side_m1);

  bsm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(dividend),
    .divisor ({cnt, 1'b0}),
    .busy    (div_busy),
    .quotient(quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      side_m1  <= CW'(RESET_SIDE - 1);
      row      <= '0;
      col      <= '0;
      scol     <= '0;
      rot      <= '0;
      flush    <= 1'b0;
      edge_sel <= 1'b0;
    end else begin
      if (cmd.load) begin
        scol <= col;
      end
      if (cmd.flush_start) begin
        flush <= 1'b1;
        scol  <= '0;
      end
      if (cmd.scan_next) begin
        scol <= scol + CW'(1);
      end
      if (cmd.edge_clr) begin
        edge_sel <= 1'b0;
      end
      if (cmd.edge_set) begin
        edge_sel <= 1'b1;
      end
      if (cmd.advance) begin
        flush <= 1'b0;
        if (col == side_m1) begin
          col <= '0;
          rot <= (rot == ROT_W'(NUM_BUFS - 1)) ? '0 : rot + ROT_W'(1);
          row <= (row == side_m1) ? '0 : row + CW'(1);
        end else begin
          col <= col + CW'(1);
        end
      end
      if (cfg_write) begin
        side_m1 <= nm1_w[CW-1:0];
        row     <= '0;
        col     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      w2 <= w1;
      w1 <= w0;
      w0 <= colsum;
    end
    if (cmd.out_load) begin
      smoothed    <= quotient[PIX_W-1:0];
      out_row     <= POS_W'(flush ? side_m1 : row - CW'(1));
      out_col     <= POS_W'(edge_sel ? scol : scol - CW'(1));
      last_of_run <= edge_sel ? (flush || !last_pixel) : (!flush && !scol_last);
      frame_done  <= flush && edge_sel;
    end
  end

  assign status.row_zero   = (row == '0);
  assign status.scol_zero  = (scol == '0);
  assign status.scol_last  = scol_last;
  assign status.last_pixel = last_pixel;
  assign status.flush      = flush;
  assign status.edge_mode  = edge_sel;
  assign status.div_busy   = div_busy;

endmodule

/* src/bsm_ctrl.sv */
// Controller state machine: sequences reads, window shifts, divisions and result handoff.
// Depends on bsm_pkg.
module bsm_ctrl
  import bsm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SUM,
    S_START,
    S_WAIT,
    S_OUT,
    S_NEXT
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.row_zero) begin
            cmd.advance = 1'b1;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.shift    = 1'b1;
        cmd.edge_clr = 1'b1;
        state_next   = status.scol_zero ? S_NEXT : S_START;
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (!status.div_busy) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          out_valid_next = 1'b0;
          if (!status.edge_mode && status.scol_last) begin
            cmd.edge_set = 1'b1;
            state_next   = S_START;
          end else begin
            state_next = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        if (status.flush) begin
          if (status.scol_last) begin
            cmd.advance = 1'b1;
            state_next  = S_IDLE;
          end else begin
            cmd.scan_next = 1'b1;
            state_next    = S_READ;
          end
        end else if (status.last_pixel) begin
          cmd.flush_start = 1'b1;
          state_next      = S_READ;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* src/box_smoothing_3x3_edge_mean.sv */
// Top level of the 3x3 box smoothing block: controller plus datapath.
// Depends on bsm_pkg, bsm_ctrl and bsm_dp (which holds bsm_ram and bsm_div).
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------------------
//  config    | cfg_write               | image_size
//  input     | in_valid / in_stall     | pixel
//  output    | out_valid / out_stall   | smoothed, out_row, out_col, last_of_run,
//            |                         | frame_done
//
// A pixel of the first row is only stored. Any other pixel passes through accept,
// read, sum and next, plus, per result it causes, start, a wait on the reciprocal
// divider, and presenting the result.
// The last pixel of a frame adds a scan of the final row: read, sum and next per
// column plus the result steps. rst is synchronous and active high; it sets
// image_size to 16 and the position to zero. A stalled result holds the block,
// and no new request is taken until the result is delivered.
module box_smoothing_3x3_edge_mean
  import bsm_pkg::*;
#(
  parameter int MAX_SIDE = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [SIZE_W-1:0] image_size,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PIX_W-1:0]  pixel,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PIX_W-1:0]  smoothed,
  output logic [POS_W-1:0]  out_row,
  output logic [POS_W-1:0]  out_col,
  output logic              last_of_run,
  output logic              frame_done
);

  // Commands drive the datapath one step at a time; status reports position
  // flags (first row, scan column at either end, last pixel), the flush mode,
  // which column the next mean is centered on, and whether the divider runs.
  cmd_t    cmd;
  status_t status;

  // Controller: accept a request, read the three line buffers at the scan
  // column, push the column sum, then for each result run the divider and
  // hold the result until the output side takes it.
  bsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: three rotating line buffers (current, recent, older row), a
  // three-column sum window, the mean divider and the output register.
  // Rows rotate by index, so no buffer copy happens at a row end.
  bsm_dp #(
    .MAX_SIDE(MAX_SIDE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .image_size (image_size),
    .pixel      (pixel),
    .cmd        (cmd),
    .status     (status),
    .smoothed   (smoothed),
    .out_row    (out_row),
    .out_col    (out_col),
    .last_of_run(last_of_run),
    .frame_done (frame_done)
  );

`ifndef NO_ASSERTIONS
  // A waiting result always holds off new requests.
  a_result_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input not stalled while a result is pending");

  // The end of a frame is always the end of that request's results.
  a_frame_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_done) |-> last_of_run)
    else $error("frame_done without last_of_run");

  // Each result goes back through the divider, so two never follow back to back.
  a_result_gap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("result presented in the cycle after a delivery");
`endif

endmodule

/* verif/tb.sv */
// Self-checking testbench for box_smoothing_3x3_edge_mean: streams square images
// through the block and checks every smoothed pixel against an in-bench predictor.
// Depends on bsm_pkg and the box_smoothing_3x3_edge_mean RTL only.
module tb
  import bsm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE_MAX     = 16;
  localparam int MAX_WAIT     = 13;  // longest idle stretch either side draws at a time
  localparam int SETTLE       = 40;  // cycles a result-free pixel may still occupy the block
  localparam int LONG_HOLD    = 400; // receiver hold-off that backs the block up
  localparam int RANDOM_ITEMS = 220;
  localparam int SHOW_LIMIT   = 10;

  typedef logic [PIX_W-1:0] pix_row_t [SIDE_MAX];

  typedef struct packed {
    logic [PIX_W-1:0] smoothed;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last_of_run;
    logic             frame_done;
  } smooth_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_write;
  logic [SIZE_W-1:0] image_size;
  logic              in_valid;
  logic              in_stall;
  logic [PIX_W-1:0]  pixel;
  logic              out_valid;
  logic              out_stall;
  logic [PIX_W-1:0]  smoothed;
  logic [POS_W-1:0]  out_row;
  logic [POS_W-1:0]  out_col;
  logic              last_of_run;
  logic              frame_done;

  box_smoothing_3x3_edge_mean #(
    .MAX_SIDE(SIDE_MAX)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .image_size (image_size),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel      (pixel),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .smoothed   (smoothed),
    .out_row    (out_row),
    .out_col    (out_col),
    .last_of_run(last_of_run),
    .frame_done (frame_done)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the size register, the two line stores,
  // the row being filled and the raster position of the next pixel.
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0] side_reg;
  pix_row_t          row_two_up;
  pix_row_t          row_one_up;
  pix_row_t          row_now;
  int                pos_row;
  int                pos_col;

  smooth_result_t    pending_means[$];  // smoothed pixels predicted, not yet seen
  int                mismatches;

  // Idling controls shared by the stimulus and the receiver.
  bit                tx_gapless;
  bit                rx_gapless;
  int                rx_hold_req;

  function automatic int side_in_use();
    if (side_reg < SIZE_W'(MIN_SIDE)) return MIN_SIDE;
    if (side_reg > SIZE_W'(SIDE_MAX)) return SIDE_MAX;
    return int'(side_reg);
  endfunction

  function automatic int draw_wait(input bit gapless);
    return gapless ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Rounded-half-up mean over the in-image part of a 3x3 window centered on col.
  // The middle row is always inside the image; upper and lower may be off it.
  function automatic logic [PIX_W-1:0] neighborhood_mean(
    input pix_row_t upper, input pix_row_t middle, input pix_row_t lower,
    input bit has_upper, input bit has_lower, input int col, input int side);
    int sum;
    int count;
    int lo;
    int hi;
    sum   = 0;
    count = 0;
    lo    = (col > 0) ? col - 1 : 0;
    hi    = (col + 1 < side) ? col + 1 : side - 1;
    for (int cc = lo; cc <= hi; cc++) begin
      sum += middle[cc];
      count++;
      if (has_upper) begin
        sum += upper[cc];
        count++;
      end
      if (has_lower) begin
        sum += lower[cc];
        count++;
      end
    end
    return PIX_W'((2 * sum + count) / (2 * count));
  endfunction

  // Work out everything one accepted pixel releases and queue it in order.
  function automatic void predict_smoothing(input logic [PIX_W-1:0] p);
    smooth_result_t batch[$];
    smooth_result_t res;
    int             side;
    int             r;
    int             c;
    bit             frame_end;
    side = side_in_use();
    r    = pos_row;
    c    = pos_col;
    if (r >= side || c >= side) begin
      r = 0;
      c = 0;
    end
    row_now[c] = p;
    frame_end  = (r == side - 1) && (c == side - 1);

    // The pixel completes the window of the pixel up and to the left; at the
    // right edge it also completes the one straight above.
    if (r >= 1 && c >= 1) begin
      res             = '0;
      res.row         = POS_W'(r - 1);
      res.col         = POS_W'(c - 1);
      res.smoothed    = neighborhood_mean(row_two_up, row_one_up, row_now,
                                          (r - 1) > 0, 1'b1, c - 1, side);
      batch.push_back(res);
      if (c == side - 1) begin
        res.col      = POS_W'(c);
        res.smoothed = neighborhood_mean(row_two_up, row_one_up, row_now,
                                         (r - 1) > 0, 1'b1, c, side);
        batch.push_back(res);
      end
    end

    // Bottom-right pixel: flush the whole final row, which has no row below.
    if (frame_end) begin
      for (int cc = 0; cc < side; cc++) begin
        res          = '0;
        res.row      = POS_W'(side - 1);
        res.col      = POS_W'(cc);
        res.smoothed = neighborhood_mean(row_one_up, row_now, row_now,
                                         1'b1, 1'b0, cc, side);
        batch.push_back(res);
      end
      batch[batch.size() - 1].frame_done = 1'b1;
    end
    if (batch.size() > 0) batch[batch.size() - 1].last_of_run = 1'b1;
    foreach (batch[i]) pending_means.push_back(batch[i]);

    // Advance the raster position, rotate the rows at the end of each row.
    c++;
    if (c == side) begin
      c          = 0;
      row_two_up = row_one_up;
      row_one_up = row_now;
      r++;
      if (r == side) r = 0;
    end
    pos_row = r;
    pos_col = c;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Drive at the falling edge, observe the handshake at the rising edge.
  // ---------------------------------------------------------------------------

  // Offer one pixel after a random gap; return once the block took it.
  task automatic offer_pixel(input logic [PIX_W-1:0] p);
    int gap;
    gap = draw_wait(tx_gapless);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    pixel    <= p;
    do @(posedge clk); while (in_stall);
    predict_smoothing(p);
  endtask

  // Drop the request line; used before register writes and at the end.
  task automatic drop_request();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait for every predicted result, then let a result-free pixel finish too.
  task automatic wait_drained();
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the size register while the block is idle; this restarts the frame.
  task automatic set_image_size(input logic [SIZE_W-1:0] value);
    drop_request();
    wait_drained();
    @(negedge clk);
    cfg_write  <= 1'b1;
    image_size <= value;
    @(negedge clk);
    cfg_write  <= 1'b0;
    side_reg = value;
    pos_row  = 0;
    pos_col  = 0;
  endtask

  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return PIX_W'($urandom_range(250, 255));
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: the receiver draws a stall stretch after each result it takes,
  // and honors a one-off long hold when a test asks for it.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        stall_left  = rx_hold_req;
        rx_hold_req = 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
      @(posedge clk);
      if (!rst && out_valid && !out_stall) stall_left = draw_wait(rx_gapless);
    end
  end

  // Compare each delivered result against the oldest prediction.
  always @(posedge clk) begin : check_results
    smooth_result_t got;
    smooth_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{smoothed, out_row, out_col, last_of_run, frame_done};
      if (pending_means.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("%0t: result with nothing pending: mean %0d at (%0d,%0d) last %b done %b",
                   $realtime, got.smoothed, got.row, got.col, got.last_of_run, got.frame_done);
      end else begin
        want = pending_means.pop_front();
        if (got.smoothed !== want.smoothed || got.row !== want.row ||
            got.col !== want.col || got.last_of_run !== want.last_of_run ||
            got.frame_done !== want.frame_done) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("%0t: exp %0d (%0d,%0d) last %b done %b, got %0d (%0d,%0d) last %b done %b",
                     $realtime, want.smoothed, want.row, want.col, want.last_of_run,
                     want.frame_done, got.smoothed, got.row, got.col, got.last_of_run,
                     got.frame_done);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Full 16x16 frame at the reset size while the receiver holds off for a long
  // stretch; the sender keeps offering, so the block backs up and stalls its input.
  task automatic test_reset_size_pressure();
    tx_gapless  = 1'b1;
    rx_gapless  = 1'b0;
    rx_hold_req = LONG_HOLD;
    repeat (SIDE_MAX * SIDE_MAX) offer_pixel(random_pixel());
    tx_gapless  = 1'b0;
  endtask

  // Smallest image: every pixel is a corner, divisor four, extreme values.
  task automatic test_smallest_image();
    set_image_size(SIZE_W'(MIN_SIDE));
    offer_pixel('1);
    offer_pixel('0);
    offer_pixel('0);
    offer_pixel('1);
  endtask

  // 3x3 of full-scale pixels hits every divisor at the top value, then carry on
  // into the next frame to check the wrap at the end of a frame.
  task automatic test_full_scale_and_wrap();
    set_image_size(SIZE_W'(3));
    repeat (9) offer_pixel('1);
    for (int i = 0; i < 5; i++) offer_pixel(PIX_W'(i * 61));
  endtask

  // Rewriting the size mid-frame restarts from the top-left pixel.
  task automatic test_restart_mid_frame();
    set_image_size(SIZE_W'(3));
    for (int i = 0; i < 5; i++) offer_pixel(PIX_W'(255 - i * 37));
  endtask

  // Sizes below the minimum act as the minimum.
  task automatic test_clamped_small_sizes();
    set_image_size(SIZE_W'(0));
    for (int i = 0; i < 4; i++) offer_pixel(PIX_W'(1 + i * 2));
    set_image_size(SIZE_W'(1));
    for (int i = 0; i < 4; i++) offer_pixel(PIX_W'(i * 85));
  endtask

  // Mostly whole small frames, some cut short by a size write, a few partial
  // frames at large or over-range sizes; idling mode changes per phase.
  task automatic test_random_frames();
    int               sent;
    int               phase;
    int               side;
    int               count;
    logic [SIZE_W-1:0] sz;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0:       sz = '1;                        // over range, acts as the maximum
        1:       sz = SIZE_W'(SIDE_MAX + 1);
        default: begin
          case ($urandom_range(0, 9))
            0:       sz = $urandom_range(0, 1) ? SIZE_W'($urandom_range(0, 1))
                                               : SIZE_W'($urandom_range(17, 31));
            1:       sz = SIZE_W'($urandom_range(9, SIDE_MAX));
            default: sz = SIZE_W'($urandom_range(MIN_SIDE, 8));
          endcase
        end
      endcase
      set_image_size(sz);
      side       = side_in_use();
      tx_gapless = ($urandom_range(0, 3) == 0);
      rx_gapless = ($urandom_range(0, 3) == 0);
      if (side > 8)
        count = $urandom_range(1, 3 * side + 4);
      else if ($urandom_range(0, 4) == 0)
        count = $urandom_range(1, side * side - 1);
      else
        count = side * side * $urandom_range(1, 2);
      repeat (count) offer_pixel(random_pixel());
      sent += count;
      phase++;
    end
    tx_gapless = 1'b0;
    rx_gapless = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst         = 1'b1;
    cfg_write   = 1'b0;
    image_size  = SIZE_W'(SIDE_MAX);
    in_valid    = 1'b0;
    pixel       = '0;
    out_stall   = 1'b0;
    side_reg    = SIZE_W'(SIDE_MAX);
    pos_row     = 0;
    pos_col     = 0;
    mismatches  = 0;
    tx_gapless  = 1'b0;
    rx_gapless  = 1'b0;
    rx_hold_req = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_size_pressure();
    test_smallest_image();
    test_full_scale_and_wrap();
    test_restart_mid_frame();
    test_clamped_small_sizes();
    test_random_frames();

    drop_request();
    wait_drained();
    if (mismatches == 0 && pending_means.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
